### rtl/ffd_pkg.sv
package ffd_pkg;

  localparam int unsigned FRAME_LEN  = 48;
  localparam int unsigned WORD_COUNT = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FILL_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_LEN - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_FIRST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_SECOND = 2'd3;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST   = 8'h7C;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST  = 8'hF4;
  localparam logic [BYTE_W-1:0] TRAILER_FIRST_RST  = 8'hE3;
  localparam logic [BYTE_W-1:0] TRAILER_SECOND_RST = 8'hEC;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] trailer_first;
    logic [BYTE_W-1:0] trailer_second;
  } sync_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] motor_position_bits;
    logic [WORD_W-1:0] motor_velocity_bits;
    logic [WORD_W-1:0] accel_x_bits;
    logic [WORD_W-1:0] accel_y_bits;
    logic [WORD_W-1:0] accel_z_bits;
    logic [WORD_W-1:0] gyro_x_bits;
    logic [WORD_W-1:0] gyro_y_bits;
    logic [WORD_W-1:0] gyro_z_bits;
    logic [WORD_W-1:0] moment_bits;
    logic [WORD_W-1:0] first_time_bits;
    logic [WORD_W-1:0] second_time_bits;
  } frame_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

### rtl/fixed_frame_deframer_48b.sv
// fixed-length frame deframer: one received byte per input beat goes into a
// 48-byte sliding window; once 48 bytes are held, the first two are checked
// against the header registers and the last two against the trailer registers.
// on a match one output beat carries the eleven little-endian 32-bit words at
// frame offsets 2 to 45 and the window empties; on a mismatch the oldest byte
// falls out and the check repeats with the next byte. a byte is taken every
// cycle while in_stall is low: the window is a shift register whose match
// logic sits in the same cycle as the shift. matched frames go through a
// two-entry queue into an output register; in_stall rises whenever both queue
// slots are full. a frame enters the queue with its last byte and then moves
// to the output register, which raises out_valid. the user must write the
// registers only while the block is idle; the block does not enforce this.
module fixed_frame_deframer_48b
  import ffd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // received bytes
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  // decoded frames
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_W-1:0]     out_motor_position_bits,
  output logic [WORD_W-1:0]     out_motor_velocity_bits,
  output logic [WORD_W-1:0]     out_accel_x_bits,
  output logic [WORD_W-1:0]     out_accel_y_bits,
  output logic [WORD_W-1:0]     out_accel_z_bits,
  output logic [WORD_W-1:0]     out_gyro_x_bits,
  output logic [WORD_W-1:0]     out_gyro_y_bits,
  output logic [WORD_W-1:0]     out_gyro_z_bits,
  output logic [WORD_W-1:0]     out_moment_bits,
  output logic [WORD_W-1:0]     out_first_time_bits,
  output logic [WORD_W-1:0]     out_second_time_bits
);

  sync_cfg_t cfg_r;
  sync_cfg_t cfg_nxt;
  logic      in_accept;
  logic      push_valid;
  frame_t    push_frame;
  q_status_t q_status;
  frame_t    q_frame;
  logic      q_pop;
  frame_t    out_frame;

  // sync byte registers, only the index that matches is touched
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:   cfg_nxt.header_first   = cfg_data;
        REG_HEADER_SECOND:  cfg_nxt.header_second  = cfg_data;
        REG_TRAILER_FIRST:  cfg_nxt.trailer_first  = cfg_data;
        REG_TRAILER_SECOND: cfg_nxt.trailer_second = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{
        header_first:   HEADER_FIRST_RST,
        header_second:  HEADER_SECOND_RST,
        trailer_first:  TRAILER_FIRST_RST,
        trailer_second: TRAILER_SECOND_RST
      };
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // hold off bytes only while a finished frame would find no slot
  assign in_stall  = q_status.full;
  assign in_accept = in_valid && !in_stall;

  // window and header/trailer check
  ffd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (in_accept),
    .rx_byte    (in_rx_byte),
    .push_valid (push_valid),
    .push_frame (push_frame)
  );

  // decouples the window from output backpressure
  ffd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_frame (push_frame),
    .pop        (q_pop),
    .status     (q_status),
    .head_frame (q_frame)
  );

  // output register
  ffd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_status.valid),
    .q_frame   (q_frame),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_frame (out_frame)
  );

  assign out_motor_position_bits = out_frame.motor_position_bits;
  assign out_motor_velocity_bits = out_frame.motor_velocity_bits;
  assign out_accel_x_bits        = out_frame.accel_x_bits;
  assign out_accel_y_bits        = out_frame.accel_y_bits;
  assign out_accel_z_bits        = out_frame.accel_z_bits;
  assign out_gyro_x_bits         = out_frame.gyro_x_bits;
  assign out_gyro_y_bits         = out_frame.gyro_y_bits;
  assign out_gyro_z_bits         = out_frame.gyro_z_bits;
  assign out_moment_bits         = out_frame.moment_bits;
  assign out_first_time_bits     = out_frame.first_time_bits;
  assign out_second_time_bits    = out_frame.second_time_bits;

`ifndef SYNTHESIS
  // a matched frame never arrives at a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_valid && q_status.full))
    else $error("frame pushed into full queue");

  // an output beat only starts from a queued frame
  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_status.valid))
    else $error("output valid without queued frame");

  // a stalled output beat keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output beat dropped");
`endif

endmodule

### rtl/ffd_front.sv
module ffd_front
  import ffd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  sync_cfg_t         cfg,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              push_valid,
  output frame_t            push_frame
);

  logic [BYTE_W-1:0] win_r [FRAME_LEN];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              match;
  logic [WORD_W-1:0] words [WORD_COUNT];

  // window after this byte: entry i is win_r[i+1], entry 47 is the new byte
  assign match = (fill_r == FILL_LAST)
              && (win_r[1] == cfg.header_first)
              && (win_r[2] == cfg.header_second)
              && (win_r[FRAME_LEN-1] == cfg.trailer_first)
              && (rx_byte == cfg.trailer_second);

  assign push_valid = accept && match;

  always_comb begin
    for (int k = 0; k < WORD_COUNT; k++) begin
      words[k] = {win_r[6+4*k], win_r[5+4*k], win_r[4+4*k], win_r[3+4*k]};
    end
  end

  assign push_frame = '{
    motor_position_bits: words[0],
    motor_velocity_bits: words[1],
    accel_x_bits:        words[2],
    accel_y_bits:        words[3],
    accel_z_bits:        words[4],
    gyro_x_bits:         words[5],
    gyro_y_bits:         words[6],
    gyro_z_bits:         words[7],
    moment_bits:         words[8],
    first_time_bits:     words[9],
    second_time_bits:    words[10]
  };

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (fill_r == FILL_LAST) begin
        fill_nxt = match ? '0 : FILL_LAST;
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[FRAME_LEN-1] <= rx_byte;
    end
  end

endmodule

### rtl/ffd_queue.sv
module ffd_queue
  import ffd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  frame_t    push_frame,
  input  logic      pop,
  output q_status_t status,
  output frame_t    head_frame
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  frame_t     slot0_r;
  frame_t     slot1_r;
  frame_t     slot0_nxt;
  frame_t     slot1_nxt;

  assign status.valid = (cnt_r != 2'd0);
  assign status.full  = (cnt_r == 2'd2);
  assign head_frame   = slot0_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    unique case (cnt_r)
      2'd0: begin
        if (push) begin
          slot0_nxt = push_frame;
          cnt_nxt   = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0_nxt = push_frame;
        end else if (push) begin
          slot1_nxt = push_frame;
          cnt_nxt   = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          slot0_nxt = slot1_r;
          cnt_nxt   = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

### rtl/ffd_back.sv
module ffd_back
  import ffd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_valid,
  input  frame_t q_frame,
  output logic   q_pop,
  input  logic   out_stall,
  output logic   out_valid,
  output frame_t out_frame
);

  logic   out_valid_r;
  logic   out_valid_nxt;
  frame_t out_frame_r;

  // load when the output register is empty or its beat is taken now
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_frame_r <= q_frame;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;

endmodule
